@@ rtl/core/clut_pixel_expander_unit_defines.svh @@
// Assertion macros shared by the pixel expander RTL.
`ifndef CLUT_PIXEL_EXPANDER_UNIT_DEFINES_SVH
`define CLUT_PIXEL_EXPANDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/clutpx_pkg.sv @@
// Shared types, constants and color expansion for the pixel expander.
package clutpx_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_4BPP  = 2'd0,
    MODE_8BPP  = 2'd1,
    MODE_16BPP = 2'd2,
    MODE_24BPP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_LUT    = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_RGB    = 2'd2
  } kind_t;

  // One pixel request handed from the issue stage to the output stage.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        last;
    logic        oob;
    logic [23:0] raw;
  } req_t;

  typedef struct packed {
    logic       last;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Expands a 1-5-5-5 color into {alpha, blue, green, red}.
  function automatic logic [31:0] expand_colour(input logic [15:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    r = {c[4:0], 3'b000};
    g = {c[9:5], 3'b000};
    b = {c[14:10], 3'b000};
    a = ((c & 16'h8000) != 16'h0000 || (c & 16'h7FFF) != 16'h0000) ? 8'hFF : 8'h00;
    return {a, b, g, r};
  endfunction

endpackage

@@ rtl/core/clutpx_palette_ram.sv @@
// Palette memory: one write port and one registered read port.
module clutpx_palette_ram import clutpx_pkg::*; #(
  parameter int ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/clutpx_issue.sv @@
// Issue stage: holds a word, writes the palette, sends a pixel request a cycle given room.
module clutpx_issue import clutpx_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          func,
  input  logic [7:0]    palette_index,
  input  logic [15:0]   data_word,
  input  logic          image_start,
  input  logic          cfg_write_en,
  input  logic [1:0]    cfg_write_data,
  input  logic          room,
  output req_t          req,
  output logic [AW-1:0] ram_raddr,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [15:0]   ram_wdata
);

  `include "clut_pixel_expander_unit_defines.svh"

  logic        busy;
  logic        item_func;
  logic [7:0]  item_index;
  logic [15:0] item_word;
  logic [1:0]  cnt;
  logic [1:0]  pack_phase;
  logic [1:0]  pack_phase_next;
  logic [31:0] held;
  logic [31:0] held_next;
  mode_t       pixel_mode;

  logic       has_pix;
  logic [1:0] last_cnt;
  logic       issue;
  logic       done;
  logic       accept;
  logic [7:0] byte_idx;
  logic [3:0] nib_idx;

  always_comb begin
    has_pix = 1'b0;
    last_cnt = 2'd0;
    if (item_func) begin
      case (pixel_mode)
        MODE_4BPP: begin
          has_pix = 1'b1;
          last_cnt = 2'd3;
        end
        MODE_8BPP: begin
          has_pix = 1'b1;
          last_cnt = 2'd1;
        end
        MODE_16BPP: begin
          has_pix = 1'b1;
          last_cnt = 2'd0;
        end
        MODE_24BPP: begin
          has_pix = (pack_phase == 2'd2);
          last_cnt = 2'd1;
        end
        default: begin
          has_pix = 1'b0;
        end
      endcase
    end
  end

  assign issue    = busy && has_pix && room;
  assign done     = busy && (!has_pix || (issue && cnt == last_cnt));
  assign in_ready = !busy || done;
  assign accept   = in_valid && in_ready;

  assign nib_idx  = item_word[4*cnt +: 4];
  assign byte_idx = cnt[0] ? item_word[15:8] : item_word[7:0];

  always_comb begin
    req = '0;
    req.valid = issue;
    req.last = (cnt == last_cnt);
    ram_raddr = '0;
    case (pixel_mode)
      MODE_4BPP: begin
        req.kind = KIND_LUT;
        ram_raddr = AW'({4'b0000, nib_idx});
      end
      MODE_8BPP: begin
        req.kind = KIND_LUT;
        req.oob = ({1'b0, byte_idx} >= 9'(PALETTE_ENTRIES));
        ram_raddr = AW'(byte_idx);
      end
      MODE_16BPP: begin
        req.kind = KIND_DIRECT;
        req.raw = {8'h00, item_word};
      end
      MODE_24BPP: begin
        req.kind = KIND_RGB;
        req.raw = cnt[0] ? {item_word[15:8], item_word[7:0], held[31:24]} : held[23:0];
      end
      default: begin
        req.kind = KIND_DIRECT;
      end
    endcase
  end

  // Palette writes go through the same slot as image words, so later lookups see them.
  assign ram_we    = busy && !item_func && ({1'b0, item_index} < 9'(PALETTE_ENTRIES));
  assign ram_waddr = AW'(item_index);
  assign ram_wdata = item_word;

  always_comb begin
    pack_phase_next = pack_phase;
    held_next = held;
    if (done && item_func && pixel_mode == MODE_24BPP) begin
      case (pack_phase)
        2'd1: begin
          held_next[31:16] = item_word;
          pack_phase_next = 2'd2;
        end
        2'd2: begin
          pack_phase_next = 2'd0;
        end
        default: begin
          held_next[15:0] = item_word;
          pack_phase_next = 2'd1;
        end
      endcase
    end
    // A start marker on the incoming word takes effect after the finishing word's update.
    if (accept && func && image_start) begin
      pack_phase_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 2'd0;
      pack_phase <= 2'd0;
      held <= 32'h0;
      pixel_mode <= MODE_16BPP;
    end else begin
      if (cfg_write_en) begin
        pixel_mode <= mode_t'(cfg_write_data);
      end
      if (done) begin
        busy <= 1'b0;
        cnt <= 2'd0;
      end else if (issue) begin
        cnt <= cnt + 2'd1;
      end
      if (accept) begin
        busy <= 1'b1;
      end
      pack_phase <= pack_phase_next;
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= func;
      item_index <= palette_index;
      item_word <= data_word;
    end
  end

  `ASSERT_IMPLIES(a_req_image_only, clk, rst, req.valid, busy && item_func, "pixel request without image word")
  `ASSERT_IMPLIES(a_phase_range, clk, rst, 1'b1, pack_phase != 2'd3, "pack phase out of range")
  `ASSERT_NEXT(a_cnt_cleared, clk, rst, done, cnt == 2'd0, "pixel count not cleared after word")

endmodule

@@ rtl/core/clutpx_out.sv @@
// Output stage: builds pixels from palette, direct or RGB data and queues them.
module clutpx_out import clutpx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic [15:0] ram_rdata,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_pixel
);

  `include "clut_pixel_expander_unit_defines.svh"

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int LW = $clog2(FIFO_DEPTH + 1);

  logic          s1_valid;
  req_t          s1;
  logic [15:0]   colour;
  logic [31:0]   rgba;
  pixel_t        pix;
  pixel_t        fifo_mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;
  logic [LW:0]   committed;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= req;
  end

  // An index beyond the palette reads as black.
  always_comb begin
    colour = 16'h0000;
    rgba = 32'h0;
    case (s1.kind)
      KIND_LUT: begin
        colour = s1.oob ? 16'h0000 : ram_rdata;
        rgba = expand_colour(colour);
      end
      KIND_DIRECT: begin
        colour = s1.raw[15:0];
        rgba = expand_colour(colour);
      end
      KIND_RGB: begin
        rgba = {8'hFF, s1.raw};
      end
      default: begin
        rgba = 32'h0;
      end
    endcase
    pix = {s1.last, rgba};
  end

  // The issue stage only sends a request if the queue has a slot for it.
  assign committed = {1'b0, level} + {{LW{1'b0}}, s1_valid};
  assign room      = committed < (LW + 1)'(FIFO_DEPTH);
  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo_mem[wr_ptr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      level <= level + LW'(s1_valid) - LW'(pop);
    end
  end

  assign red        = fifo_mem[rd_ptr].red;
  assign green      = fifo_mem[rd_ptr].green;
  assign blue       = fifo_mem[rd_ptr].blue;
  assign alpha      = fifo_mem[rd_ptr].alpha;
  assign last_pixel = fifo_mem[rd_ptr].last;

  `ASSERT_IMPLIES(a_push_has_slot, clk, rst, s1_valid, level < LW'(FIFO_DEPTH), "pixel queue overflow")
  `ASSERT_IMPLIES(a_level_bound, clk, rst, 1'b1, level <= LW'(FIFO_DEPTH), "pixel queue level too high")
  `ASSERT_NEXT(a_level_hold, clk, rst, !s1_valid && !pop, level == $past(level), "queue level moved while idle")

endmodule

@@ rtl/core/clut_pixel_expander_unit.sv @@
// Top level of the palette/direct texture word to RGBA8888 pixel expander.
// Each accepted word yields pixels one per cycle while the output queue has room: four in
// 4 bpp mode, two in 8 bpp mode, one in 16 bpp mode, and in 24 bpp mode none for either of
// the two buffering words and two for the word that completes a pixel pair; a palette
// write yields none. The single palette read port and the one pixel a cycle output set
// that rate. A request is registered with its palette read, then its pixel enters a
// four-entry output queue that lets new words enter while finished pixels wait to be taken.
module clut_pixel_expander_unit import clutpx_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  palette_index,
  input  logic [15:0] data_word,
  input  logic        image_start,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_pixel
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  req_t          req;
  logic          room;
  logic [AW-1:0] ram_raddr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  clutpx_issue #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .AW(AW)
  ) u_issue (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .palette_index(palette_index),
    .data_word(data_word),
    .image_start(image_start),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .room(room),
    .req(req),
    .ram_raddr(ram_raddr),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  clutpx_palette_ram #(
    .ENTRIES(PALETTE_ENTRIES),
    .AW(AW)
  ) u_palette (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  clutpx_out u_out (
    .clk(clk),
    .rst(rst),
    .req(req),
    .ram_rdata(ram_rdata),
    .room(room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha(alpha),
    .last_pixel(last_pixel)
  );

endmodule

@@ bench/tb_clut_pixel_expander_unit.sv @@
// Self-checking testbench for the palette texture word to RGBA pixel expander.
module tb_clut_pixel_expander_unit import clutpx_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } rgba_px_t;

  typedef struct packed {
    mode_t       mode;
    logic        func;
    logic [7:0]  idx;
    logic [15:0] data;
    logic        start;
    logic        typed;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [7:0]  palette_index;
  logic [15:0] data_word;
  logic        image_start;
  logic        cfg_write_en;
  logic [1:0]  cfg_write_data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last_pixel;

  // Shadow of the block state used to predict pixels.
  logic [15:0] clut_shadow [256];
  bit          clut_set [256];
  logic [7:0]  filled_idx [$];
  logic [1:0]  pair_phase;
  logic [31:0] held_bytes;
  mode_t       cur_mode;

  rgba_px_t    pending_px [$];
  int          fail_count;
  int          words_sent;
  stim_row_t   dir_rows [26];

  clut_pixel_expander_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .palette_index  (palette_index),
    .data_word      (data_word),
    .image_start    (image_start),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .last_pixel     (last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200us;
    $display("Some tests failed");
    $finish;
  end

  function automatic rgba_px_t colour_px(input logic [15:0] c, input logic last);
    rgba_px_t p;
    p.r    = {c[4:0], 3'b000};
    p.g    = {c[9:5], 3'b000};
    p.b    = {c[14:10], 3'b000};
    // Only an all-zero color without STP is transparent.
    p.a    = (c != 16'h0000) ? 8'hFF : 8'h00;
    p.last = last;
    return p;
  endfunction

  function automatic rgba_px_t rgb_px(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic last);
    rgba_px_t p;
    p = {r, g, b, 8'hFF, last};
    return p;
  endfunction

  // Updates the shadow state for one word and returns the pixels it yields.
  function automatic int expand_word(input logic f, input logic [7:0] idx,
                                     input logic [15:0] w, input logic s,
                                     output rgba_px_t px [4]);
    int n;
    n = 0;
    if (!f) begin
      clut_shadow[idx] = w;
    end else begin
      if (s) pair_phase = 2'd0;
      case (cur_mode)
        MODE_4BPP: begin
          for (int i = 0; i < 4; i++) px[i] = colour_px(clut_shadow[w[4*i +: 4]], i == 3);
          n = 4;
        end
        MODE_8BPP: begin
          px[0] = colour_px(clut_shadow[w[7:0]], 1'b0);
          px[1] = colour_px(clut_shadow[w[15:8]], 1'b1);
          n = 2;
        end
        MODE_16BPP: begin
          px[0] = colour_px(w, 1'b1);
          n = 1;
        end
        default: begin
          case (pair_phase)
            2'd1: begin
              held_bytes[31:16] = w;
              pair_phase = 2'd2;
            end
            2'd2: begin
              px[0] = rgb_px(held_bytes[7:0], held_bytes[15:8], held_bytes[23:16], 1'b0);
              px[1] = rgb_px(held_bytes[31:24], w[7:0], w[15:8], 1'b1);
              pair_phase = 2'd0;
              n = 2;
            end
            default: begin
              held_bytes[15:0] = w;
              pair_phase = 2'd1;
            end
          endcase
        end
      endcase
    end
    return n;
  endfunction

  // Offers one word, waits for it to be taken, and records the pixels it should yield.
  task automatic issue_word(input logic f, input logic [7:0] idx, input logic [15:0] w,
                            input logic s, input logic typed, input rgba_px_t typed_px);
    rgba_px_t px [4];
    int n;
    if (!(words_sent >= 40 && words_sent < 75) && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid      <= 1'b1;
    func          <= f;
    palette_index <= idx;
    data_word     <= w;
    image_start   <= s;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (!f && !clut_set[idx]) begin
      clut_set[idx] = 1'b1;
      filled_idx.push_back(idx);
    end
    n = expand_word(f, idx, w, s, px);
    if (typed) begin
      pending_px.push_back(typed_px);
    end else begin
      for (int j = 0; j < n; j++) pending_px.push_back(px[j]);
    end
  endtask

  // Waits until the block has delivered everything and any word without pixels has cleared.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_mode = m;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rgba_px_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_px.size() == 0) begin
        $error("pixel: expected none, got %0d/%0d/%0d/%0d", red, green, blue, alpha);
        fail_count++;
      end else begin
        want = pending_px.pop_front();
        check_field("red", want.r, red);
        check_field("green", want.g, green);
        check_field("blue", want.b, blue);
        check_field("alpha", want.a, alpha);
        check_field("last_pixel", {7'd0, want.last}, {7'd0, last_pixel});
      end
    end
  end

  // Receiver: random stalls, one long hold-off while words keep coming, then a steady stretch.
  initial begin
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!held && taken >= 60 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      out_ready <= (taken >= 70 && taken < 120) || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin
    mode_t       phase_modes [4];
    mode_t       m;
    logic [31:0] rnd;
    logic [15:0] w;
    logic        s;
    int          sent;
    int          k;
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = 1'b0;
    palette_index  = 8'h00;
    data_word      = 16'h0000;
    image_start    = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = 2'd0;
    fail_count     = 0;
    words_sent     = 0;
    pair_phase     = 2'd0;
    held_bytes     = 32'h0;
    cur_mode       = MODE_16BPP;
    phase_modes    = '{MODE_4BPP, MODE_24BPP, MODE_8BPP, MODE_16BPP};

    dir_rows = '{
      // Direct colors straight after reset: transparent black, STP only, full white.
      '{MODE_16BPP, 1'b1, 8'h00, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_16BPP, 1'b1, 8'h00, 16'h8000, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'hFF},
      '{MODE_16BPP, 1'b1, 8'h00, 16'h7FFF, 1'b0, 1'b1, 8'hF8, 8'hF8, 8'hF8, 8'hFF},
      '{MODE_16BPP, 1'b1, 8'hFF, 16'hFFFF, 1'b0, 1'b1, 8'hF8, 8'hF8, 8'hF8, 8'hFF},
      '{MODE_16BPP, 1'b1, 8'h00, 16'h0001, 1'b1, 1'b1, 8'h08, 8'h00, 8'h00, 8'hFF},
      '{MODE_16BPP, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_16BPP, 1'b0, 8'h0F, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_16BPP, 1'b0, 8'h01, 16'h7FFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_16BPP, 1'b0, 8'hFF, 16'h8000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_4BPP,  1'b1, 8'h00, 16'hF10F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_4BPP,  1'b1, 8'hFF, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_8BPP,  1'b1, 8'h00, 16'hFF00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_8BPP,  1'b1, 8'h00, 16'h0F01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'h1234, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'hABCD, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      // A start marker in the middle of a triple restarts the packing.
      '{MODE_24BPP, 1'b1, 8'h00, 16'h00FF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'h5A5A, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'hA5A5, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      // The packing position survives a trip through another mode.
      '{MODE_24BPP, 1'b1, 8'h00, 16'h1111, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_16BPP, 1'b1, 8'h00, 16'h2222, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'h3333, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_24BPP, 1'b1, 8'h00, 16'h4444, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      // A start marker in direct mode still clears the packing position.
      '{MODE_24BPP, 1'b1, 8'h00, 16'h6666, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{MODE_16BPP, 1'b1, 8'h00, 16'h7777, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) begin
        drain_block();
        set_mode(dir_rows[i].mode);
      end
      issue_word(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].data, dir_rows[i].start,
                 dir_rows[i].typed, {dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                 dir_rows[i].a, 1'b1});
    end

    // Fill the entries that 4 bpp words can reach before any random lookup.
    for (k = 0; k < 16; k++) begin
      rnd = $urandom;
      issue_word(1'b0, k[7:0], rnd[15:0], rnd[16], 1'b0, '0);
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) m = phase_modes[ph];
      else m = mode_t'($urandom_range(0, 3));
      if (m != cur_mode) begin
        drain_block();
        set_mode(m);
      end
      sent = 0;
      while (sent < 9) begin
        rnd = $urandom;
        w = rnd[15:0];
        s = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 99) < 20) begin
          issue_word(1'b0, rnd[23:16], w, s, 1'b0, '0);
          sent++;
        end else begin
          case (m)
            MODE_8BPP: begin
              w = {filled_idx[$urandom_range(0, filled_idx.size() - 1)],
                   filled_idx[$urandom_range(0, filled_idx.size() - 1)]};
              issue_word(1'b1, rnd[23:16], w, s, 1'b0, '0);
              sent++;
            end
            MODE_24BPP: begin
              if ($urandom_range(0, 3) == 0) begin
                // Stray word that may break the current triple.
                issue_word(1'b1, rnd[23:16], w, rnd[31], 1'b0, '0);
                sent++;
              end else begin
                for (int j = 0; j < 3; j++) begin
                  rnd = $urandom;
                  s = (j == 0) && ($urandom_range(0, 3) != 0);
                  issue_word(1'b1, rnd[23:16], rnd[15:0], s, 1'b0, '0);
                end
                sent += 3;
              end
            end
            default: begin
              issue_word(1'b1, rnd[23:16], w, s, 1'b0, '0);
              sent++;
            end
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    k = 0;
    while (pending_px.size() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    if (pending_px.size() != 0) begin
      $error("pixels: expected %0d more, got none", pending_px.size());
      fail_count++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ clut_pixel_expander_unit.f @@
+incdir+rtl/core
rtl/core/clutpx_pkg.sv
rtl/core/clutpx_palette_ram.sv
rtl/core/clutpx_issue.sv
rtl/core/clutpx_out.sv
rtl/core/clut_pixel_expander_unit.sv
bench/tb_clut_pixel_expander_unit.sv
